[src/tacsc_pkg.sv]
// ----------------------------------------------------------------------------
// tacsc_pkg: shared types and constants of the three-axis speed controller
// Holds register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tacsc_pkg;

    // Width of the configuration register index
    localparam int CFG_IDX_BITS = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TARGET_AXIS1 = 3'd0,
        REG_TARGET_AXIS2 = 3'd1,
        REG_TARGET_AXIS3 = 3'd2,
        REG_MAX_SPEED    = 3'd3,
        REG_TOLERANCE    = 3'd4
    } tacsc_reg_t;

    // Register reset values
    localparam int RST_MAX_SPEED = 40;
    localparam int RST_TOLERANCE = 5;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } tacsc_state_t;

endpackage

`default_nettype wire

[src/tacsc_in_if.sv]
// ----------------------------------------------------------------------------
// tacsc_in_if: tick request channel
// Carries the start bit and the three potentiometer readings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tacsc_in_if #(
    parameter int POS_BITS = 10
);
    logic                valid;
    logic                ready;
    logic                start_req;
    logic [POS_BITS-1:0] pos_axis1;
    logic [POS_BITS-1:0] pos_axis2;
    logic [POS_BITS-1:0] pos_axis3;

    modport source (output valid, start_req, pos_axis1, pos_axis2, pos_axis3,
                    input ready);
    modport sink   (input valid, start_req, pos_axis1, pos_axis2, pos_axis3,
                    output ready);
endinterface

`default_nettype wire

[src/tacsc_out_if.sv]
// ----------------------------------------------------------------------------
// tacsc_out_if: motor command channel
// Carries the run flag and the direction and duty of each axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tacsc_out_if #(
    parameter int SPEED_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic                  running;
    logic                  dir_axis1;
    logic [SPEED_BITS-1:0] speed_axis1;
    logic                  dir_axis2;
    logic [SPEED_BITS-1:0] speed_axis2;
    logic                  dir_axis3;
    logic [SPEED_BITS-1:0] speed_axis3;

    modport source (output valid, running, dir_axis1, speed_axis1, dir_axis2,
                    speed_axis2, dir_axis3, speed_axis3,
                    input ready);
    modport sink   (input valid, running, dir_axis1, speed_axis1, dir_axis2,
                    speed_axis2, dir_axis3, speed_axis3,
                    output ready);
endinterface

`default_nettype wire

[src/tacsc_lane.sv]
// ----------------------------------------------------------------------------
// tacsc_lane: per-axis error lane
// Registers the absolute error and the drive direction of one axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tacsc_lane #(
    parameter int POS_BITS = 10
) (
    input  wire logic                clk,
    input  wire logic                load,
    input  wire logic [POS_BITS-1:0] target,
    input  wire logic [POS_BITS-1:0] pos,
    output logic      [POS_BITS-1:0] err,
    output logic                     dir
);

    logic [POS_BITS-1:0] err_reg;
    logic [POS_BITS-1:0] err_next;
    logic                dir_reg;
    logic                dir_next;

    // Forward when the goal lies above the reading
    always_comb
    begin
        dir_next = (target > pos);
        err_next = dir_next ? (target - pos) : (pos - target);
    end

    // Capture on a new tick
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg <= err_next;
            dir_reg <= dir_next;
        end
    end

    assign err = err_reg;
    assign dir = dir_reg;

endmodule

`default_nettype wire

[src/tacsc_div.sv]
// ----------------------------------------------------------------------------
// tacsc_div: scaled speed divider
// Forms speed*err and divides it by the lead error, one quotient bit per
// cycle (restoring), then saturates at full-scale duty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tacsc_div #(
    parameter int POS_BITS   = 10,
    parameter int SPEED_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [SPEED_BITS-1:0] speed,
    input  wire logic [POS_BITS-1:0]   err,
    input  wire logic [POS_BITS-1:0]   lead,
    output logic                       busy,
    output logic      [SPEED_BITS-1:0] quo
);

    localparam int NUM_BITS = SPEED_BITS + POS_BITS;
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic                busy_reg;
    logic                busy_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic [NUM_BITS-1:0] quo_reg;
    logic [NUM_BITS-1:0] quo_next;
    logic [POS_BITS-1:0] rem_reg;
    logic [POS_BITS-1:0] rem_next;
    logic [POS_BITS-1:0] den_reg;
    logic [POS_BITS-1:0] den_next;
    logic [POS_BITS:0]   rem_shift;
    logic [POS_BITS:0]   rem_diff;

    // Load the product, then shift one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_shift = {rem_reg, quo_reg[NUM_BITS-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(NUM_BITS);
            quo_next  = NUM_BITS'(speed * err);
            rem_next  = '0;
            den_next  = lead;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_diff[POS_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[POS_BITS-1:0];
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // Saturate at full scale; a zero lead yields all ones and saturates too
    assign quo  = (quo_reg[NUM_BITS-1:SPEED_BITS] != '0) ? '1
                                                          : quo_reg[SPEED_BITS-1:0];
    assign busy = busy_reg;

endmodule

`default_nettype wire

[src/three_axis_coordinated_speed_ctrl.sv]
// ----------------------------------------------------------------------------
// three_axis_coordinated_speed_ctrl: coordinated speed controller
// Three error lanes, a lead-axis merge and two divider lanes give each axis
// a duty proportional to its error, with an arrived latch that pauses all.
//
//   channel   dir  handshake            payload
//   in_ch     in   valid/ready          start_req, pos_axis1..3
//   out_ch    out  valid/ready          running, dir/speed_axis1..3
//   cfg       in   cfg_we (no stall)    cfg_index, cfg_data
//
// A moving tick passes from the accepting edge through evaluation and the
// bit-serial dividers to the loaded result; a paused tick goes from
// evaluation straight to the result. One tick is worked at a time, and the
// next request is taken in the cycle after the result loads. The result
// register frees the input while a result waits; a stalled output holds
// the next result in the divider lanes. Reset sets the arrived latch and
// the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_axis_coordinated_speed_ctrl
    import tacsc_pkg::*;
#(
    parameter int POS_BITS   = 10,
    parameter int SPEED_BITS = 8,
    localparam int CFG_BITS  = (POS_BITS > SPEED_BITS) ? POS_BITS : SPEED_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]     cfg_data,
    tacsc_in_if.sink                     in_ch,
    tacsc_out_if.source                  out_ch
);

    // Configuration registers
    logic [POS_BITS-1:0]   target1_reg;
    logic [POS_BITS-1:0]   target2_reg;
    logic [POS_BITS-1:0]   target3_reg;
    logic [SPEED_BITS-1:0] max_speed_reg;
    logic [POS_BITS-1:0]   tolerance_reg;

    // Control
    tacsc_state_t state_reg;
    tacsc_state_t state_next;
    logic         arrived_reg;
    logic         arrived_next;
    logic         paused_reg;
    logic         paused_next;
    logic         lead1_reg;
    logic         lead1_next;
    logic         lead_zero_reg;
    logic         lead_zero_next;
    logic         in_accept;
    logic         div_start;
    logic         out_load;

    // Lanes
    logic [POS_BITS-1:0]   err1;
    logic [POS_BITS-1:0]   err2;
    logic [POS_BITS-1:0]   err3;
    logic                  dir1;
    logic                  dir2;
    logic                  dir3;
    logic [POS_BITS-1:0]   lead_err;
    logic [POS_BITS-1:0]   other_err;
    logic                  lead1_now;
    logic                  stop_now;
    logic                  busy_a;
    logic                  busy_b;
    logic [SPEED_BITS-1:0] quo_a;
    logic [SPEED_BITS-1:0] quo_b;

    // Result register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  running_reg;
    logic                  dir1_reg;
    logic                  dir2_reg;
    logic                  dir3_reg;
    logic [SPEED_BITS-1:0] speed1_reg;
    logic [SPEED_BITS-1:0] speed2_reg;
    logic [SPEED_BITS-1:0] speed3_reg;
    logic                  running_next;
    logic                  dir1_next;
    logic                  dir2_next;
    logic                  dir3_next;
    logic [SPEED_BITS-1:0] speed1_next;
    logic [SPEED_BITS-1:0] speed2_next;
    logic [SPEED_BITS-1:0] speed3_next;

    assign in_accept = in_ch.valid && in_ch.ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target1_reg   <= '0;
            target2_reg   <= '0;
            target3_reg   <= '0;
            max_speed_reg <= SPEED_BITS'(RST_MAX_SPEED);
            tolerance_reg <= POS_BITS'(RST_TOLERANCE);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_AXIS1: target1_reg   <= cfg_data[POS_BITS-1:0];
                REG_TARGET_AXIS2: target2_reg   <= cfg_data[POS_BITS-1:0];
                REG_TARGET_AXIS3: target3_reg   <= cfg_data[POS_BITS-1:0];
                REG_MAX_SPEED:    max_speed_reg <= cfg_data[SPEED_BITS-1:0];
                REG_TOLERANCE:    tolerance_reg <= cfg_data[POS_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Error lanes, one per axis
    tacsc_lane #(.POS_BITS(POS_BITS)) u_lane1 (
        .clk    (clk),
        .load   (in_accept),
        .target (target1_reg),
        .pos    (in_ch.pos_axis1),
        .err    (err1),
        .dir    (dir1)
    );

    tacsc_lane #(.POS_BITS(POS_BITS)) u_lane2 (
        .clk    (clk),
        .load   (in_accept),
        .target (target2_reg),
        .pos    (in_ch.pos_axis2),
        .err    (err2),
        .dir    (dir2)
    );

    tacsc_lane #(.POS_BITS(POS_BITS)) u_lane3 (
        .clk    (clk),
        .load   (in_accept),
        .target (target3_reg),
        .pos    (in_ch.pos_axis3),
        .err    (err3),
        .dir    (dir3)
    );

    // Merge: pick the lead actuator (axis2 on a tie) and test for a stop (arrival or a zero actuator target)
    always_comb
    begin
        lead1_now = (err1 > err2);
        lead_err  = lead1_now ? err1 : err2;
        other_err = lead1_now ? err2 : err1;
        stop_now  = (target1_reg == '0) || (target2_reg == '0) ||
                    ((err1 <= tolerance_reg) && (err2 <= tolerance_reg) &&
                     (err3 <= tolerance_reg));
    end

    // Divider lanes: the other actuator and the turntable
    tacsc_div #(.POS_BITS(POS_BITS), .SPEED_BITS(SPEED_BITS)) u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .speed (max_speed_reg),
        .err   (other_err),
        .lead  (lead_err),
        .busy  (busy_a),
        .quo   (quo_a)
    );

    tacsc_div #(.POS_BITS(POS_BITS), .SPEED_BITS(SPEED_BITS)) u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .speed (max_speed_reg),
        .err   (err3),
        .lead  (lead_err),
        .busy  (busy_b),
        .quo   (quo_b)
    );

    // Sequencer: next state and strobes
    always_comb
    begin
        state_next     = state_reg;
        arrived_next   = arrived_reg;
        paused_next    = paused_reg;
        lead1_next     = lead1_reg;
        lead_zero_next = lead_zero_reg;
        in_ch.ready    = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    // A start request clears the latch before evaluation
                    arrived_next = arrived_reg && !in_ch.start_req;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (arrived_reg || stop_now)
                begin
                    arrived_next = 1'b1;
                    paused_next  = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    paused_next    = 1'b0;
                    lead1_next     = lead1_now;
                    lead_zero_next = (lead_err == '0);
                    div_start      = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!busy_a && !busy_b)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            arrived_reg   <= 1'b1;
            paused_reg    <= 1'b1;
            lead1_reg     <= 1'b0;
            lead_zero_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            arrived_reg   <= arrived_next;
            paused_reg    <= paused_next;
            lead1_reg     <= lead1_next;
            lead_zero_reg <= lead_zero_next;
        end
    end

    // Assemble the result; zero everything when paused
    always_comb
    begin
        running_next = 1'b0;
        dir1_next    = 1'b0;
        dir2_next    = 1'b0;
        dir3_next    = 1'b0;
        speed1_next  = '0;
        speed2_next  = '0;
        speed3_next  = '0;
        if (!paused_reg)
        begin
            running_next = 1'b1;
            dir1_next    = dir1;
            dir2_next    = dir2;
            dir3_next    = dir3;
            speed3_next  = quo_b;
            if (lead1_reg)
            begin
                speed1_next = max_speed_reg;
                speed2_next = quo_a;
            end
            else
            begin
                speed2_next = max_speed_reg;
                speed1_next = lead_zero_reg ? '0 : quo_a;
            end
        end
    end

    // Result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            running_reg <= running_next;
            dir1_reg    <= dir1_next;
            dir2_reg    <= dir2_next;
            dir3_reg    <= dir3_next;
            speed1_reg  <= speed1_next;
            speed2_reg  <= speed2_next;
            speed3_reg  <= speed3_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.running     = running_reg;
    assign out_ch.dir_axis1   = dir1_reg;
    assign out_ch.speed_axis1 = speed1_reg;
    assign out_ch.dir_axis2   = dir2_reg;
    assign out_ch.speed_axis2 = speed2_reg;
    assign out_ch.dir_axis3   = dir3_reg;
    assign out_ch.speed_axis3 = speed3_reg;

endmodule

`default_nettype wire

[src/tacsc_chk.sv]
// ----------------------------------------------------------------------------
// tacsc_chk: port checker for the coordinated speed controller
// Watches the channels of the top level and flags illegal behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tacsc_chk #(
    parameter int SPEED_BITS = 8
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic                  running,
    input wire logic                  dir_axis1,
    input wire logic [SPEED_BITS-1:0] speed_axis1,
    input wire logic                  dir_axis2,
    input wire logic [SPEED_BITS-1:0] speed_axis2,
    input wire logic                  dir_axis3,
    input wire logic [SPEED_BITS-1:0] speed_axis3
);

    // A paused result drives nothing
    a_paused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !running) |->
            (!dir_axis1 && !dir_axis2 && !dir_axis3 && speed_axis1 == '0 &&
             speed_axis2 == '0 && speed_axis3 == '0))
        else $error("paused result carries a nonzero command");

    // One tick at a time: no request is taken right after another
    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a tick is in progress");

    // A result is never produced in the cycle right after a request
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result appeared too early");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(running) && $stable(speed_axis1) &&
             $stable(speed_axis2) && $stable(speed_axis3) &&
             $stable(dir_axis1) && $stable(dir_axis2) && $stable(dir_axis3)))
        else $error("stalled result changed");

endmodule

bind three_axis_coordinated_speed_ctrl tacsc_chk #(.SPEED_BITS(SPEED_BITS)) u_tacsc_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .running     (out_ch.running),
    .dir_axis1   (out_ch.dir_axis1),
    .speed_axis1 (out_ch.speed_axis1),
    .dir_axis2   (out_ch.dir_axis2),
    .speed_axis2 (out_ch.speed_axis2),
    .dir_axis3   (out_ch.dir_axis3),
    .speed_axis3 (out_ch.speed_axis3)
);

`default_nettype wire
